// File: src/slfq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slfq_pkg;

  localparam int LINE_BYTES = 32;
  localparam int LINE_SLOTS = 4;

  // One spare slot holds the line being assembled.
  localparam int PHYS_SLOTS = LINE_SLOTS + 1;
  localparam int SLOT_W     = $clog2(PHYS_SLOTS);
  localparam int POS_W      = $clog2(LINE_BYTES);
  localparam int ADDR_W     = SLOT_W + POS_W;
  localparam int RAM_DEPTH  = PHYS_SLOTS << POS_W;
  localparam int LIMIT_POS  = LINE_BYTES - 2;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [7:0] END_FIRST_RESET  = 8'd13;
  localparam logic [7:0] END_SECOND_RESET = 8'd10;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    REG_END_FIRST  = 1'b0,
    REG_END_SECOND = 1'b1
  } reg_idx_t;

  typedef enum logic {
    STAT_CHAR    = 1'b0,
    STAT_NO_LINE = 1'b1
  } stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

// File: src/slfq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module slfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/serial_line_framer_queue.sv
// Serial line framer with a queue of received lines.
//
// Input channel (in_valid/in_ready): operation 0 delivers one received byte in
// rx_byte, operation 1 asks for the oldest queued line. Output channel
// (out_valid/out_ready) answers each read with the line's characters, one per
// transfer, then a zero with last set, or a single transfer with status set
// when no line is queued. Received bytes give no output.
// Bytes may follow back to back. The first answer of a read appears in the
// cycle after its transfer, and further characters follow one per cycle
// from the line memory read port while out_ready is high; in_ready stays
// low until the final transfer of the answer has completed. Output
// characters are held in the memory's read register, which keeps them
// stable while out_ready is low.
// The end characters are written through the APB port at addresses 0 and 4.
// Reset empties the queue, clears the line being assembled and restores the
// end characters to 13 and 10; the line memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module serial_line_framer_queue import slfq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              operation,
  input  wire logic [7:0]        rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   status,
  output logic      [7:0]        char_out,
  output logic                   last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  state_t            state;
  state_t            state_next;
  logic [7:0]        end_char_first;
  logic [7:0]        end_char_second;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic [SLOT_W-1:0] line_count;
  logic [POS_W-1:0]  char_position;
  logic              awaiting_second;
  logic              line_terminated;
  logic [POS_W-1:0]  read_index;
  logic              no_line;

  logic              byte_acc;
  logic              read_acc;
  logic              cfg_wr;
  logic [7:0]        stored;
  logic              line_done;
  logic              await_set;
  logic              queue_full;
  logic              queue_empty;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              pop;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign byte_acc = in_valid && in_ready && (op_t'(operation) == OP_BYTE);
  assign read_acc = in_valid && in_ready && (op_t'(operation) == OP_READ);

  assign queue_full  = line_count == SLOT_W'(LINE_SLOTS);
  assign queue_empty = line_count == '0;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_END_FIRST:  prdata = {{(CFG_DW-8){1'b0}}, end_char_first};
      REG_END_SECOND: prdata = {{(CFG_DW-8){1'b0}}, end_char_second};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    stored    = (rx_byte == end_char_first) ? 8'd0 : rx_byte;
    line_done = 1'b0;
    await_set = 1'b0;
    if ((rx_byte == end_char_first) || awaiting_second) begin
      if ((end_char_second == 8'd0) || (stored == end_char_second)) begin
        line_done = 1'b1;
      end else begin
        await_set = 1'b1;
      end
    end
    if (!line_done && (char_position >= POS_W'(LIMIT_POS))) begin
      stored    = 8'd0;
      line_done = 1'b1;
    end
  end

  // The line under assembly lives in the one slot outside the queue, so the
  // write port never touches an entry that the read port can reach.
  assign ram_we    = byte_acc && !line_terminated;
  assign ram_waddr = {write_slot, char_position};

  slfq_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (stored),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status   = no_line;
  assign char_out = no_line ? 8'd0 : ram_rdata;
  assign last     = no_line || (ram_rdata == 8'd0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (read_acc && !queue_empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (out_ready && last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {read_slot, read_index};
    pop       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (read_acc && !queue_empty) begin
          ram_re    = 1'b1;
          ram_raddr = {read_slot, {POS_W{1'b0}}};
        end
      end
      ST_READ: begin
        ram_re = out_ready && !last;
        pop    = out_ready && last;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      end_char_first  <= END_FIRST_RESET;
      end_char_second <= END_SECOND_RESET;
      write_slot      <= '0;
      read_slot       <= '0;
      line_count      <= '0;
      char_position   <= '0;
      awaiting_second <= 1'b0;
      line_terminated <= 1'b0;
      out_valid       <= 1'b0;
      no_line         <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[2]))
          REG_END_FIRST:  end_char_first  <= pwdata[7:0];
          REG_END_SECOND: end_char_second <= pwdata[7:0];
          default:        end_char_first  <= end_char_first;
        endcase
      end

      if (byte_acc) begin
        if (line_done) begin
          if (!queue_full) begin
            write_slot <= (write_slot == SLOT_W'(PHYS_SLOTS - 1)) ? '0
                                                                  : write_slot + SLOT_W'(1);
            line_count <= line_count + SLOT_W'(1);
          end
          char_position   <= '0;
          awaiting_second <= 1'b0;
          line_terminated <= 1'b0;
        end else begin
          char_position <= char_position + POS_W'(1);
          if (await_set) begin
            awaiting_second <= 1'b1;
          end
          if (ram_we && (stored == 8'd0)) begin
            line_terminated <= 1'b1;
          end
        end
      end

      if (pop) begin
        read_slot  <= (read_slot == SLOT_W'(PHYS_SLOTS - 1)) ? '0 : read_slot + SLOT_W'(1);
        line_count <= line_count - SLOT_W'(1);
      end

      if (read_acc) begin
        out_valid <= 1'b1;
        no_line   <= queue_empty;
      end else if (out_valid && out_ready && ((state == ST_IDLE) || last)) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (read_acc) begin
      read_index <= POS_W'(1);
    end else if ((state == ST_READ) && ram_re) begin
      read_index <= read_index + POS_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: src/slfq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module slfq_checker import slfq_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              operation,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              status,
  input wire logic [7:0]        char_out,
  input wire logic              last
);

  // Reset leaves no transfer pending on the output.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Every accepted read request is answered in the following cycle.
  a_read_answer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_READ)) |=> out_valid)
    else $error("read request not answered");

  // The no-line status is a single transfer carrying zero.
  a_no_line_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_NO_LINE)) |-> (last && (char_out == 8'd0)))
    else $error("malformed no-line status");

  // The final transfer of a line carries the zero terminator.
  a_last_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_CHAR) && last) |-> (char_out == 8'd0))
    else $error("final character not zero");

  // A stalled answer holds its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(char_out) && $stable(status)
                                   && $stable(last)))
    else $error("output changed while stalled");

endmodule

bind serial_line_framer_queue slfq_checker u_slfq_checker (.*);

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import slfq_pkg::*;

  typedef struct packed {
    stat_t      status;
    logic [7:0] ch;
    logic       last;
  } line_char_t;

  typedef struct {
    op_t        op;
    logic [7:0] rx;
    logic       typed;
    line_char_t ans;
  } script_row_t;

  localparam line_char_t NO_ANSWER  = '0;
  localparam line_char_t EMPTY_READ = '{STAT_NO_LINE, 8'h00, 1'b1};
  localparam line_char_t BLANK_LINE = '{STAT_CHAR, 8'h00, 1'b1};
  localparam int HOLD_CYCLES = 300;

  localparam logic [7:0] T1 = END_FIRST_RESET;
  localparam logic [7:0] T2 = END_SECOND_RESET;

  // Lines A, B (blank), C and D (blank) fill the queue, so line E is dropped
  // and the fifth read finds the queue empty.
  script_row_t script [24] = '{
    '{OP_READ, 8'hFF, 1'b1, EMPTY_READ},
    '{OP_BYTE, 8'hFF, 1'b0, NO_ANSWER},
    '{OP_BYTE, 8'h01, 1'b0, NO_ANSWER},
    '{OP_BYTE, 8'h80, 1'b0, NO_ANSWER},
    '{OP_BYTE, T1,    1'b0, NO_ANSWER},
    '{OP_BYTE, T2,    1'b0, NO_ANSWER},
    '{OP_BYTE, T1,    1'b0, NO_ANSWER},
    '{OP_BYTE, T2,    1'b0, NO_ANSWER},
    '{OP_BYTE, 8'h61, 1'b0, NO_ANSWER},
    '{OP_BYTE, 8'h00, 1'b0, NO_ANSWER},
    '{OP_BYTE, 8'h62, 1'b0, NO_ANSWER},
    '{OP_BYTE, T1,    1'b0, NO_ANSWER},
    '{OP_BYTE, 8'h78, 1'b0, NO_ANSWER},
    '{OP_BYTE, T2,    1'b0, NO_ANSWER},
    '{OP_BYTE, T1,    1'b0, NO_ANSWER},
    '{OP_BYTE, T2,    1'b0, NO_ANSWER},
    '{OP_BYTE, 8'h55, 1'b0, NO_ANSWER},
    '{OP_BYTE, T1,    1'b0, NO_ANSWER},
    '{OP_BYTE, T2,    1'b0, NO_ANSWER},
    '{OP_READ, 8'h00, 1'b0, NO_ANSWER},
    '{OP_READ, 8'h00, 1'b1, BLANK_LINE},
    '{OP_READ, 8'hFF, 1'b0, NO_ANSWER},
    '{OP_READ, 8'hFF, 1'b1, BLANK_LINE},
    '{OP_READ, 8'h00, 1'b1, EMPTY_READ}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              operation;
  logic [7:0]        rx_byte;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              status;
  logic [7:0]        char_out;
  logic              last;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  logic       typed_on;
  line_char_t typed_answer;

  line_char_t  answer_q [$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned stalls_asked = 0;
  int unsigned stalls_granted = 0;
  int unsigned stall_left = 0;

  logic [7:0]  cfg_first = END_FIRST_RESET;
  logic [7:0]  cfg_second = END_SECOND_RESET;
  logic [7:0]  slot_text [LINE_SLOTS][LINE_BYTES];
  logic [7:0]  build_buf [LINE_BYTES] = '{default: 8'h00};
  int unsigned wr_slot = 0;
  int unsigned rd_slot = 0;
  int unsigned queued_lines = 0;
  int unsigned build_pos = 0;
  bit          wait_second = 1'b0;
  bit          text_closed = 1'b0;

  serial_line_framer_queue u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .char_out  (char_out),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic void frame_byte(input logic [7:0] b);
    logic [7:0]  kept;
    bit          done;
    int unsigned k;
    kept = b;
    done = 1'b0;
    if (b == cfg_first || wait_second) begin
      if (b == cfg_first) kept = 8'h00;
      if (cfg_second == 8'h00 || kept == cfg_second) done = 1'b1;
      else wait_second = 1'b1;
    end
    if (!done && build_pos >= LIMIT_POS) begin
      kept = 8'h00;
      done = 1'b1;
    end
    if (!text_closed && build_pos < LINE_BYTES) begin
      build_buf[build_pos] = kept;
      if (kept == 8'h00) text_closed = 1'b1;
    end
    if (done) begin
      if (queued_lines < LINE_SLOTS) begin
        for (k = 0; k < LIMIT_POS && build_buf[k] != 8'h00; k++)
          slot_text[wr_slot][k] = build_buf[k];
        slot_text[wr_slot][k] = 8'h00;
        wr_slot = (wr_slot + 1) % LINE_SLOTS;
        queued_lines++;
      end
      build_pos = 0;
      wait_second = 1'b0;
      text_closed = 1'b0;
    end else begin
      build_pos++;
    end
  endfunction

  function automatic void frame_read();
    int unsigned k;
    if (queued_lines == 0) begin
      answer_q.push_back(EMPTY_READ);
    end else begin
      for (k = 0; k < LIMIT_POS && slot_text[rd_slot][k] != 8'h00; k++)
        answer_q.push_back(line_char_t'{STAT_CHAR, slot_text[rd_slot][k], 1'b0});
      answer_q.push_back(BLANK_LINE);
      rd_slot = (rd_slot + 1) % LINE_SLOTS;
      queued_lines--;
    end
  endfunction

  always @(posedge clk) begin : monitor
    int unsigned n;
    line_char_t  want;
    if (!rst && in_valid && in_ready) begin
      n = answer_q.size();
      if (op_t'(operation) == OP_READ) frame_read();
      else frame_byte(rx_byte);
      if (typed_on) begin
        while (answer_q.size() > n) void'(answer_q.pop_back());
        answer_q.push_back(typed_answer);
      end
    end
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        error_count++;
        $error("unexpected output transfer: status %0d char_out %0d last %0d",
               status, char_out, last);
      end else begin
        want = answer_q.pop_front();
        if (status !== want.status) begin
          error_count++;
          $error("status: expected %0d, got %0d", want.status, status);
        end
        if (char_out !== want.ch) begin
          error_count++;
          $error("char_out: expected %0d, got %0d", want.ch, char_out);
        end
        if (last !== want.last) begin
          error_count++;
          $error("last: expected %0d, got %0d", want.last, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_granted != stalls_asked) begin
      stalls_granted <= stalls_asked;
      stall_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input op_t op, input logic [7:0] b,
                           input logic typed = 1'b0, input line_char_t ans = NO_ANSWER);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    rx_byte <= b;
    typed_on <= typed;
    typed_answer <= ans;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_line();
    int unsigned len;
    int unsigned i;
    if (cfg_second != 8'h00 && cfg_first == cfg_second) len = $urandom_range(20, 34);
    else if ($urandom_range(0, 5) == 0) len = $urandom_range(26, 34);
    else len = $urandom_range(0, 8);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(OP_BYTE, 8'h00);
      else send_item(OP_BYTE, 8'($urandom_range(1, 255)));
    end
    send_item(OP_BYTE, cfg_first);
    if (cfg_second != 8'h00) begin
      repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      send_item(OP_BYTE, cfg_second);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) send_item(OP_READ, 8'($urandom_range(0, 255)));
      else if (pick < 38) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      else send_line();
    end
  endtask

  // Bytes give no answer, so the task waits on after the answer queue drains, for the last one to land.
  task automatic settle();
    in_valid <= 1'b0;
    typed_on <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(input reg_idx_t idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'({idx, 2'b00});
    pwdata <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_END_FIRST) cfg_first = val;
    else cfg_second = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(val)) begin
      error_count++;
      $error("prdata: expected %0d, got %0d", val, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = 1'b0;
    rx_byte = 8'h00;
    typed_on = 1'b0;
    typed_answer = NO_ANSWER;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 38;
    rx_idle_pct = 75;
    foreach (script[i]) send_item(script[i].op, script[i].rx, script[i].typed, script[i].ans);
    settle();
    set_register(REG_END_FIRST, 8'hFF);
    set_register(REG_END_SECOND, 8'h00);
    run_random(20);

    settle();
    tx_idle_pct = 75;
    rx_idle_pct = 38;
    set_register(REG_END_FIRST, 8'h00);
    set_register(REG_END_SECOND, 8'hFF);
    run_random(20);

    // Equal end characters: lines close only at the length limit.
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_register(REG_END_FIRST, 8'hFF);
    set_register(REG_END_SECOND, 8'hFF);
    run_random(30);

    settle();
    set_register(REG_END_FIRST, END_FIRST_RESET);
    set_register(REG_END_SECOND, END_SECOND_RESET);
    send_line();
    send_line();
    stalls_asked++;
    repeat (3) begin
      send_item(OP_READ, 8'($urandom_range(0, 255)));
      send_line();
    end
    run_random(10);

    in_valid <= 1'b0;
    typed_on <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// File: sim.f
src/slfq_pkg.sv
src/slfq_ram.sv
src/serial_line_framer_queue.sv
src/slfq_checker.sv
dv/testbench.sv
